FILE: rtl/core/nttbf_pkg.sv
package nttbf_pkg;

    // Field widths fixed by the interface
    localparam int unsigned ResW    = 30;
    localparam int unsigned BitsW   = 5;
    localparam int unsigned FactorW = 31;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 31;

    // Working widths of the Barrett datapath
    localparam int unsigned DiffW = 32;
    localparam int unsigned ProdW = 62;
    localparam int unsigned WideW = 64;
    localparam int unsigned HalfW = 32;

    localparam int unsigned NumStages = 8;

    typedef logic [ResW-1:0]    res_t;
    typedef logic [BitsW-1:0]   bits_t;
    typedef logic [FactorW-1:0] factor_t;
    typedef logic [CfgIdxW-1:0] cfg_idx_t;
    typedef logic [CfgDatW-1:0] cfg_dat_t;

    // Register map
    localparam cfg_idx_t CfgModulus       = 2'd0;
    localparam cfg_idx_t CfgModulusBits   = 2'd1;
    localparam cfg_idx_t CfgBarrettFactor = 2'd2;

    // Reset values
    localparam res_t    ModulusRst = 30'd12289;
    localparam bits_t   BitsRst    = 5'd14;
    localparam factor_t FactorRst  = 31'd21843;

    // Barrett shift offset
    localparam bits_t ShiftOfs = 5'd2;

endpackage

FILE: rtl/core/ntt_butterfly_barrett_top.sv
// Gentleman-Sande NTT butterfly with Barrett reduction
//
//  channel | signals                                   | direction | accepted when
//  --------+-------------------------------------------+-----------+------------------------
//  input   | in_valid, in_stall, first_in, second_in,  | in        | in_valid && !in_stall
//          | twiddle                                   |           |
//  output  | out_valid, out_stall, sum_out, product_out| out       | out_valid && !out_stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | cfg_valid && cfg_ready
//
// Throughput is one transaction per cycle while out_stall is low; the eight
// register stages of the datapath each hold one multiply, one multiplier pair
// or one wide add.
// Reset (rst_n low, asynchronous) clears all stage valid bits and loads the
// modulus, bit count and Barrett factor with their defaults.
// Each stage advances whenever the stage after it can take data, so bubbles
// collapse; in_stall rises only when all eight stages hold data and out_stall
// is high. The config port is always ready.
module ntt_butterfly_barrett_top (
    input  logic                clk,
    input  logic                rst_n,
    // input transactions
    input  logic                in_valid,
    output logic                in_stall,
    input  nttbf_pkg::res_t     first_in,
    input  nttbf_pkg::res_t     second_in,
    input  nttbf_pkg::res_t     twiddle,
    // result transactions
    output logic                out_valid,
    input  logic                out_stall,
    output nttbf_pkg::res_t     sum_out,
    output nttbf_pkg::res_t     product_out,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  nttbf_pkg::cfg_idx_t cfg_index,
    input  nttbf_pkg::cfg_dat_t cfg_data
);
    import nttbf_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    res_t    modulus_reg;
    bits_t   bits_reg;
    factor_t factor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= ModulusRst;
            bits_reg    <= BitsRst;
            factor_reg  <= FactorRst;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CfgModulus:       modulus_reg <= cfg_data[ResW-1:0];
                CfgModulusBits:   bits_reg    <= cfg_data[BitsW-1:0];
                CfgBarrettFactor: factor_reg  <= cfg_data[FactorW-1:0];
                default:          ;
            endcase
        end
    end

    // Shift amounts: w-2 (floored at zero) and w+2
    logic [BitsW-1:0] shift_pre;
    logic [BitsW:0]   shift_post;

    assign shift_pre  = (bits_reg >= ShiftOfs) ? (bits_reg - ShiftOfs) : '0;
    assign shift_post = {1'b0, bits_reg} + {1'b0, ShiftOfs};

    // ------------------------------------------------------------------
    // Stage valid bits and per-stage advance
    // ------------------------------------------------------------------
    logic [NumStages-1:0] valid_reg;
    logic [NumStages-1:0] ready;

    // A stage may load when it is empty or the stage after it loads too
    always_comb
    begin
        ready[NumStages-1] = !valid_reg[NumStages-1] || !out_stall;
        for (int k = NumStages - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[NumStages-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NumStages; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: modular sum and modular difference
    // ------------------------------------------------------------------
    logic [ResW:0]      sum_raw;
    res_t               sum_next;
    logic [DiffW-1:0]   diff_raw;
    logic [DiffW-1:0]   diff_next;
    logic [DiffW-1:0]   diff_reg;
    res_t               tw_reg;

    // The sum travels down the whole pipe; stage 7 holds the output copy
    res_t               sum_pipe_reg [NumStages];

    always_comb
    begin
        sum_raw  = {1'b0, first_in} + {1'b0, second_in};
        sum_next = (sum_raw >= {1'b0, modulus_reg}) ?
                   ResW'(sum_raw - {1'b0, modulus_reg}) : sum_raw[ResW-1:0];
        // a + q - b wraps at 32 bits
        diff_raw  = {2'b0, first_in} + {2'b0, modulus_reg} - {2'b0, second_in};
        diff_next = (diff_raw >= {2'b0, modulus_reg}) ?
                    (diff_raw - {2'b0, modulus_reg}) : diff_raw;
    end

    // ------------------------------------------------------------------
    // Stage 1: t = diff * twiddle
    // Stage 2: Barrett estimate, first multiply split in two halves
    // Stage 3: recombine, shift down to quotient estimate
    // Stage 4: quotient times modulus, split in two halves
    // Stage 5: recombine
    // Stage 6: t - s*q
    // Stage 7: single correction, output register
    // ------------------------------------------------------------------
    logic [ProdW-1:0]   t_next;
    logic [ProdW-1:0]   t_pipe_reg [1:5];

    logic [ProdW-1:0]   x1;
    logic [ProdW:0]     plo_next;
    logic [HalfW-1:0]   phi_next;
    logic [ProdW:0]     plo_reg;
    logic [HalfW-1:0]   phi_reg;

    logic [WideW-1:0]   x2;
    logic [WideW-1:0]   quot_next;
    logic [WideW-1:0]   quot_reg;

    logic [ProdW-1:0]   rlo_next;
    logic [HalfW-1:0]   rhi_next;
    logic [ProdW-1:0]   rlo_reg;
    logic [HalfW-1:0]   rhi_reg;

    logic [WideW-1:0]   r_next;
    logic [WideW-1:0]   r_reg;

    logic [WideW-1:0]   c_next;
    logic [WideW-1:0]   c_reg;

    res_t               prod_next;
    res_t               prod_reg;

    always_comb
    begin
        t_next = ProdW'(diff_reg) * ProdW'(tw_reg);

        x1       = t_pipe_reg[1] >> shift_pre;
        plo_next = (ProdW+1)'(x1[HalfW-1:0]) * (ProdW+1)'(factor_reg);
        phi_next = HalfW'({2'b0, x1[ProdW-1:HalfW]} * {1'b0, factor_reg});

        x2        = {1'b0, plo_reg} + {phi_reg, {HalfW{1'b0}}};
        quot_next = x2 >> shift_post;

        rlo_next = ProdW'(quot_reg[HalfW-1:0]) * ProdW'(modulus_reg);
        rhi_next = HalfW'(quot_reg[WideW-1:HalfW] * {2'b0, modulus_reg});

        r_next = {2'b0, rlo_reg} + {rhi_reg, {HalfW{1'b0}}};

        c_next = {2'b0, t_pipe_reg[5]} - r_reg;

        prod_next = (c_reg >= {34'b0, modulus_reg}) ?
                    ResW'(c_reg - {34'b0, modulus_reg}) : c_reg[ResW-1:0];
    end

    // Payload registers: load on advance, no reset
    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            sum_pipe_reg[0] <= sum_next;
            diff_reg        <= diff_next;
            tw_reg          <= twiddle;
        end
        for (int k = 1; k < NumStages; k++)
        begin
            if (ready[k])
            begin
                sum_pipe_reg[k] <= sum_pipe_reg[k-1];
            end
        end
        if (ready[1])
        begin
            t_pipe_reg[1] <= t_next;
        end
        for (int k = 2; k <= 5; k++)
        begin
            if (ready[k])
            begin
                t_pipe_reg[k] <= t_pipe_reg[k-1];
            end
        end
        if (ready[2])
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (ready[3])
        begin
            quot_reg <= quot_next;
        end
        if (ready[4])
        begin
            rlo_reg <= rlo_next;
            rhi_reg <= rhi_next;
        end
        if (ready[5])
        begin
            r_reg <= r_next;
        end
        if (ready[6])
        begin
            c_reg <= c_next;
        end
        if (ready[7])
        begin
            prod_reg <= prod_next;
        end
    end

    assign sum_out     = sum_pipe_reg[NumStages-1];
    assign product_out = prod_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Stall input only when every stage is full and the output is held
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
        else $error("input stalled while the pipeline has room");

    // An accepted transaction lands in stage 0
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted transaction lost at pipeline entry");

    // With the output free, stage 6 data always advances to the output register
    a_tail_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_stall && valid_reg[NumStages-2]) |=> valid_reg[NumStages-1])
        else $error("pipeline tail failed to advance");

    // A held output transaction is still there next cycle
    a_output_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(prod_reg)))
        else $error("stalled result changed");

endmodule

FILE: verif/ntt_butterfly_barrett_top_tb.sv
module ntt_butterfly_barrett_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nttbf_pkg::*;

    // Runaway guard on the cycle count; far above the slowest legal run
    localparam int unsigned CycleLimit  = 400000;
    // Cycles to let the datapath settle after the last result
    localparam int unsigned SettleCycles = 12;
    localparam int unsigned ItemsPerPhase = 56;
    localparam int unsigned SqueezeCycles = 150;
    localparam res_t        AllOnes = '1;

    // One butterfly request and the pair of residues it produces
    typedef struct packed {
        res_t a;
        res_t b;
        res_t tw;
    } butterfly_operands_t;

    typedef struct packed {
        res_t sum;
        res_t prod;
    } butterfly_result_t;

    // One register setting plus how both sides behave while it is active
    typedef struct {
        res_t    q;
        bits_t   w;
        factor_t u;
        bit      tx_idle;
        bit      rx_idle;
    } setting_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;

    logic     in_valid = 1'b0;
    logic     in_stall;
    res_t     first_in = '0;
    res_t     second_in = '0;
    res_t     twiddle = '0;

    logic     out_valid;
    logic     out_stall = 1'b0;
    res_t     sum_out;
    res_t     product_out;

    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = CfgModulus;
    cfg_dat_t cfg_data = '0;

    // Testbench copy of the configuration registers
    res_t     cur_modulus = ModulusRst;
    bits_t    cur_bits = BitsRst;
    factor_t  cur_factor = FactorRst;

    butterfly_operands_t operand_queue[$];
    butterfly_result_t   expected_results[$];

    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;
    bit          squeeze_go = 1'b0;
    logic        hold_off = 1'b0;
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    ntt_butterfly_barrett_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .first_in   (first_in),
        .second_in  (second_in),
        .twiddle    (twiddle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sum_out    (sum_out),
        .product_out(product_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Expected butterfly output under the current register copy. The sum and
    // difference live in 32 bits with unsigned wraparound, exactly one
    // conditional correction each; the difference is not truncated before
    // the multiply. All Barrett steps wrap at 64 bits.
    function automatic butterfly_result_t predict_butterfly(res_t a, res_t b, res_t tw);
        butterfly_result_t res;
        bit [31:0]   q32;
        bit [31:0]   sum32;
        bit [31:0]   diff32;
        bit [63:0]   q64;
        bit [63:0]   full;
        bit [63:0]   scaled;
        bit [63:0]   quot;
        bit [63:0]   rem;
        int unsigned sh1;
        int unsigned sh2;
        q32 = {2'b00, cur_modulus};
        q64 = {34'd0, cur_modulus};
        sum32 = {2'b00, a} + {2'b00, b};
        if (sum32 >= q32)
            sum32 = sum32 - q32;
        diff32 = {2'b00, a} + q32 - {2'b00, b};
        if (diff32 >= q32)
            diff32 = diff32 - q32;
        // Shift amounts: w-2 clamps at zero for a bit count below two
        sh1 = (cur_bits >= 2) ? int'(cur_bits) - 2 : 0;
        sh2 = int'(cur_bits) + 2;
        full = {32'd0, diff32} * {34'd0, tw};
        scaled = (full >> sh1) * {33'd0, cur_factor};
        quot = scaled >> sh2;
        rem = full - quot * q64;
        if (rem >= q64)
            rem = rem - q64;
        res.sum = sum32[29:0];
        res.prod = rem[29:0];
        return res;
    endfunction

    // Barrett factor floor(2^(2w)/q), clamped to the register width
    function automatic factor_t barrett_for(res_t q, bits_t w);
        bit [63:0] quo;
        if (q == 0)
            return '1;
        quo = (64'd1 << (2 * w)) / {34'd0, q};
        return (quo > 64'h7FFF_FFFF) ? '1 : quo[30:0];
    endfunction

    // Gap or stall length for one transaction; at least a third of draws stay at zero
    // so runs of back-to-back traffic appear even with idling on
    function automatic int unsigned draw_wait(bit enabled);
        if (!enabled || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Operand biased toward the edges of the current modulus and the field
    function automatic res_t pick_operand(res_t q);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return q - 1'b1;
            2:       return q;
            3:       return AllOnes;
            4, 5:    return res_t'($urandom());
            default: return (q == 0) ? res_t'($urandom()) : res_t'($urandom_range(0, q - 1));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Write all three registers back to back; hold valid high between
    // writes and update the local copy on each accepted write
    task automatic write_settings(res_t q, bits_t w, factor_t u);
        cfg_idx_t idx[3];
        cfg_dat_t val[3];
        idx[0] = CfgModulus;
        idx[1] = CfgModulusBits;
        idx[2] = CfgBarrettFactor;
        val[0] = {1'b0, q};
        val[1] = {26'd0, w};
        val[2] = u;
        @(posedge clk);
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[i])
                CfgModulus:       cur_modulus = val[i][29:0];
                CfgModulusBits:   cur_bits = val[i][4:0];
                CfgBarrettFactor: cur_bits = cur_bits;
                default:          cur_bits = cur_bits;
            endcase
            if (idx[i] == CfgBarrettFactor)
                cur_factor = val[i][30:0];
        end
        cfg_valid <= 1'b0;
    endtask

    // Block until every queued request is accepted and every result is back,
    // then give the pipeline time to go quiet
    task automatic wait_drained();
        @(negedge clk);
        while (operand_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Input driver: log a prediction for each accepted transaction, then
    // either idle out the drawn gap or present the next queued request.
    // The payload only moves while the channel is free, so a stalled
    // transaction stays put.
    always @(posedge clk or negedge rst_n)
    begin : feed
        butterfly_operands_t op;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            first_in <= '0;
            second_in <= '0;
            twiddle <= '0;
            tx_wait <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(predict_butterfly(first_in, second_in, twiddle));
            if (!in_valid || !in_stall)
            begin
                if (tx_wait != 0)
                begin
                    in_valid <= 1'b0;
                    tx_wait <= tx_wait - 1;
                end
                else if (operand_queue.size() != 0)
                begin
                    op = operand_queue.pop_front();
                    first_in <= op.a;
                    second_in <= op.b;
                    twiddle <= op.tw;
                    in_valid <= 1'b1;
                    tx_wait <= draw_wait(tx_idle);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted transaction with the oldest
    // prediction, then draw how long to stall before taking the next one.
    // The long hold-off overrides the drawn stall.
    always @(posedge clk or negedge rst_n)
    begin : drain
        int unsigned stall_cycles;
        butterfly_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait <= 0;
        end
        else
        begin
            stall_cycles = rx_wait;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result sum=%0d product=%0d with no butterfly pending",
                                              sum_out, product_out));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (sum_out !== want.sum)
                        report_mismatch($sformatf("sum_out got %0d expected %0d (q=%0d)",
                                                  sum_out, want.sum, cur_modulus));
                    if (product_out !== want.prod)
                        report_mismatch($sformatf("product_out got %0d expected %0d (q=%0d w=%0d u=%0d)",
                                                  product_out, want.prod, cur_modulus,
                                                  cur_bits, cur_factor));
                end
                stall_cycles = draw_wait(rx_idle);
            end
            out_stall <= hold_off || (stall_cycles != 0);
            rx_wait <= (stall_cycles != 0) ? stall_cycles - 1 : 0;
        end
    end

    // Long receiver hold-off, counted here on its own; the sender keeps
    // offering meanwhile, so the pipeline fills and in_stall must rise
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (SqueezeCycles) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Runaway guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        setting_t            plan[$];
        setting_t            s;
        butterfly_operands_t op;
        res_t                q;
        bits_t               w;

        // Reset values first, then the extremes and the odd corners, then
        // random consistent settings, one fully random setting, and back to
        // the reset values written explicitly
        plan.push_back('{ModulusRst, BitsRst, FactorRst, 1'b1, 1'b1});
        plan.push_back('{30'd2, 5'd2, barrett_for(30'd2, 5'd2), 1'b1, 1'b0});
        plan.push_back('{30'd3329, 5'd12, barrett_for(30'd3329, 5'd12), 1'b0, 1'b1});
        plan.push_back('{AllOnes, 5'd30, barrett_for(AllOnes, 5'd30), 1'b1, 1'b1});
        plan.push_back('{30'd8380417, 5'd23, barrett_for(30'd8380417, 5'd23), 1'b0, 1'b0});
        // bit count below two: first shift clamps at zero
        plan.push_back('{30'd3, 5'd1, 31'd5, 1'b1, 1'b1});
        plan.push_back('{30'd3, 5'd0, 31'd1, 1'b1, 1'b0});
        // inconsistent settings: products wrap at 64 bits
        plan.push_back('{AllOnes, 5'd31, '1, 1'b0, 1'b1});
        // zero modulus, and a modulus of one
        plan.push_back('{30'd0, 5'd0, 31'd0, 1'b1, 1'b1});
        plan.push_back('{30'd1, 5'd1, 31'd0, 1'b1, 1'b0});
        for (int i = 0; i < 3; i++)
        begin
            w = bits_t'($urandom_range(2, 30));
            q = res_t'($urandom_range((1 << (w - 1)), (1 << w) - 1));
            if (q < 2)
                q = 2;
            plan.push_back('{q, w, barrett_for(q, w), bit'(i != 1), bit'(i != 2)});
        end
        plan.push_back('{res_t'($urandom()), bits_t'($urandom()), factor_t'($urandom()),
                         1'b1, 1'b1});
        plan.push_back('{ModulusRst, BitsRst, FactorRst, 1'b1, 1'b1});

        // Hold reset low, then release it on a clock edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < plan.size(); p++)
        begin
            s = plan[p];
            // Phase 0 runs on the reset values without touching the registers
            if (p != 0)
                write_settings(s.q, s.w, s.u);
            @(negedge clk);
            tx_idle = s.tx_idle;
            rx_idle = s.rx_idle;
            q = cur_modulus;

            if (p == 0)
            begin
                // Directed corners: field extremes, equal operands, operands
                // at or above the modulus, wrapping difference, bit patterns
                operand_queue.push_back('{30'd0, 30'd0, 30'd0});
                operand_queue.push_back('{q - 1'b1, q - 1'b1, q - 1'b1});
                operand_queue.push_back('{q - 1'b1, 30'd0, q - 1'b1});
                operand_queue.push_back('{30'd0, q - 1'b1, q - 1'b1});
                operand_queue.push_back('{30'd0, 30'd1, 30'd1});
                operand_queue.push_back('{30'd1, 30'd0, q - 1'b1});
                operand_queue.push_back('{q - 1'b1, 30'd1, 30'd2});
                operand_queue.push_back('{30'd5, 30'd5, 30'd7});
                operand_queue.push_back('{AllOnes, AllOnes, AllOnes});
                operand_queue.push_back('{AllOnes, 30'd0, AllOnes});
                operand_queue.push_back('{30'd0, AllOnes, AllOnes});
                operand_queue.push_back('{q, q, 30'd1});
                operand_queue.push_back('{q, 30'd0, q - 1'b1});
                operand_queue.push_back('{30'h2AAA_AAAA, 30'h1555_5555, AllOnes});
                operand_queue.push_back('{30'h1555_5555, 30'h2AAA_AAAA, 30'h2AAA_AAAA});
            end

            for (int n = 0; n < ItemsPerPhase; n++)
            begin
                op.a = pick_operand(q);
                op.b = pick_operand(q);
                op.tw = pick_operand(q);
                operand_queue.push_back(op);
            end

            // Squeeze the pipeline during the back-to-back phase
            if (p == 2)
                squeeze_go = 1'b1;

            wait_drained();
        end

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d butterflies never produced a result",
                                      expected_results.size()));
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/nttbf_pkg.sv
rtl/core/ntt_butterfly_barrett_top.sv
verif/ntt_butterfly_barrett_top_tb.sv
